// ===== design/rbp_pkg.sv =====
// Shared types, codes and helpers for the RNA base-pair maximiser
`default_nettype none
package rbp_pkg;

    localparam int DEF_MAX_LEN    = 64;
    localparam int RESULT_CAP     = 32;
    localparam int MID_FIFO_DEPTH = 2;
    localparam int OUT_FIFO_DEPTH = 4;
    localparam int GAP_W          = 4;
    localparam int OUT_W          = 6;

    localparam logic [GAP_W-1:0] GAP_RESET = 4'd3;

    localparam logic [2:0] BASE_A = 3'd0;
    localparam logic [2:0] BASE_C = 3'd1;
    localparam logic [2:0] BASE_G = 3'd2;
    localparam logic [2:0] BASE_U = 3'd3;

    typedef struct packed {
        logic [2:0] base;
        logic       last_base;
        logic       keep;
        logic       overflow;
    } t_mid_item;

    typedef struct packed {
        logic [OUT_W-1:0] pair_left;
        logic [OUT_W-1:0] pair_right;
        logic             pair_valid;
        logic [OUT_W-1:0] pair_total;
        logic             length_overflow;
        logic             last_pair;
    } t_result;

    // Watson-Crick and wobble pairs, either order
    function automatic logic can_pair(input logic [2:0] a, input logic [2:0] b);
        return (a == BASE_A && b == BASE_U) || (a == BASE_U && b == BASE_A) ||
               (a == BASE_C && b == BASE_G) || (a == BASE_G && b == BASE_C) ||
               (a == BASE_G && b == BASE_U) || (a == BASE_U && b == BASE_G);
    endfunction

endpackage
`default_nettype wire

// ===== design/rbp_ram.sv =====
// Generic RAM: one write port, two registered read ports
`default_nettype none
module rbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output      logic [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output      logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule
`default_nettype wire

// ===== design/rbp_fifo.sv =====
// Small register queue used between stages and on the result side
`default_nettype none
module rbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output      logic             o_full,
    input  wire logic             i_pop,
    output      logic [WIDTH-1:0] o_rdata,
    output      logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [NW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== design/rbp_front.sv =====
// Front end: accepts bases, counts the sequence and marks dropped bases
`default_nettype none
module rbp_front
    import rbp_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [2:0] i_base,
    input  wire logic       i_last_base,
    input  wire logic       i_mid_full,
    output      logic       o_mid_push,
    output      t_mid_item  o_mid_item
);

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          keep;

    assign keep       = (r_cnt < CW'(MAX_LEN));
    assign o_mid_push = i_push && !i_mid_full;

    always_comb begin
        o_mid_item.base      = i_base;
        o_mid_item.last_base = i_last_base;
        o_mid_item.keep      = keep;
        o_mid_item.overflow  = r_ovf || !keep;
    end

    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (o_mid_push) begin
            if (keep) begin
                n_cnt = r_cnt + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
            if (i_last_base) begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

endmodule
`default_nettype wire

// ===== design/rbp_back.sv =====
// Back end: base store, score table fill and stack walk-back
`default_nettype none
module rbp_back
    import rbp_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [GAP_W-1:0] i_gap,
    input  wire logic             i_mid_empty,
    input  wire t_mid_item        i_mid_item,
    output      logic             o_mid_pop,
    input  wire logic             i_res_full,
    output      logic             o_res_push,
    output      t_result          o_res
);

    localparam int PW  = $clog2(MAX_LEN);
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int SW  = $clog2(MAX_LEN / 2 + 1);
    localparam int TAW = 2 * PW;

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_FSTART = 17'h00002,
        S_C0     = 17'h00004,
        S_C1     = 17'h00008,
        S_C2     = 17'h00010,
        S_SPLIT  = 17'h00020,
        S_FWR    = 17'h00040,
        S_WINIT  = 17'h00080,
        S_WTOT   = 17'h00100,
        S_PUSH   = 17'h00200,
        S_POP    = 17'h00400,
        S_GET    = 17'h00800,
        S_T1     = 17'h01000,
        S_T2     = 17'h02000,
        S_EMIT   = 17'h04000,
        S_WSPLIT = 17'h08000,
        S_FIN    = 17'h10000
    } t_back_state;

    t_back_state r_state, n_state;

    logic [CW-1:0]  r_wr, n_wr, r_n, n_n, r_sp, n_sp;
    logic           r_ovf, n_ovf;
    logic [PW-1:0]  r_span, n_span, r_i, n_i, r_j, n_j, r_k, n_k, r_kc, n_kc;
    logic [PW-1:0]  r_pi, n_pi, r_pj, n_pj, r_hl, n_hl, r_hr, n_hr;
    logic [SW-1:0]  r_best, n_best, r_v, n_v, r_total, n_total;
    logic           r_sv, n_sv, r_za, n_za, r_zb, n_zb, r_pr, n_pr;
    logic           r_two, n_two, r_hv, n_hv;
    logic [5:0]     r_cnt, n_cnt;

    logic [PW-1:0]  ta_i, ta_j, tb_i, tb_j;
    logic           t_we;
    logic [SW-1:0]  t_rda, t_rdb, sa, sb;
    logic [2:0]     b_rda, b_rdb;
    logic           b_we;
    logic           st_we;
    logic [PW-1:0]  st_raddr;
    logic [TAW-1:0] st_rdata_a, st_rdata_b;
    logic [PW-1:0]  g_i, g_j;
    logic [PW-1:0]  i1, jm1;
    logic [SW:0]    sum_ab, sa1, sb1;
    logic           pair, issue;

    assign sa     = r_za ? '0 : t_rda;
    assign sb     = r_zb ? '0 : t_rdb;
    assign sum_ab = (SW+1)'(sa) + (SW+1)'(sb);
    assign sa1    = (SW+1)'(sa) + (SW+1)'(1);
    assign sb1    = (SW+1)'(sb) + (SW+1)'(1);
    assign i1     = r_i + PW'(1);
    assign jm1    = r_j - PW'(1);
    assign g_i    = st_rdata_a[TAW-1:PW];
    assign g_j    = st_rdata_b[PW-1:0];
    assign pair   = can_pair(b_rda, b_rdb) && (r_j > r_i) &&
                    ((PW+GAP_W)'(r_j - r_i) > (PW+GAP_W)'(i_gap));
    assign issue  = (r_k < r_j);
    assign b_we   = o_mid_pop && i_mid_item.keep;

    rbp_ram #(.WIDTH(3), .DEPTH(MAX_LEN)) u_base_ram (
        .i_clk     (i_clk),
        .i_we      (b_we),
        .i_waddr   (r_wr[PW-1:0]),
        .i_wdata   (i_mid_item.base),
        .i_raddr_a (r_i),
        .o_rdata_a (b_rda),
        .i_raddr_b (r_j),
        .o_rdata_b (b_rdb)
    );

    rbp_ram #(.WIDTH(SW), .DEPTH(2 ** TAW)) u_score_ram (
        .i_clk     (i_clk),
        .i_we      (t_we),
        .i_waddr   ({r_i, r_j}),
        .i_wdata   (r_best),
        .i_raddr_a ({ta_i, ta_j}),
        .o_rdata_a (t_rda),
        .i_raddr_b ({tb_i, tb_j}),
        .o_rdata_b (t_rdb)
    );

    // both ports read the top entry: left bound from one, right bound from the other
    rbp_ram #(.WIDTH(TAW), .DEPTH(MAX_LEN)) u_stack_ram (
        .i_clk     (i_clk),
        .i_we      (st_we),
        .i_waddr   (r_sp[PW-1:0]),
        .i_wdata   ({r_pi, r_pj}),
        .i_raddr_a (st_raddr),
        .o_rdata_a (st_rdata_a),
        .i_raddr_b (st_raddr),
        .o_rdata_b (st_rdata_b)
    );

    always_comb begin
        n_state = r_state;
        n_wr    = r_wr;
        n_n     = r_n;
        n_sp    = r_sp;
        n_ovf   = r_ovf;
        n_span  = r_span;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_kc    = r_kc;
        n_pi    = r_pi;
        n_pj    = r_pj;
        n_hl    = r_hl;
        n_hr    = r_hr;
        n_best  = r_best;
        n_v     = r_v;
        n_total = r_total;
        n_sv    = r_sv;
        n_pr    = r_pr;
        n_two   = r_two;
        n_hv    = r_hv;
        n_cnt   = r_cnt;
        n_za    = 1'b1;
        n_zb    = 1'b1;
        ta_i    = r_i;
        ta_j    = r_j;
        tb_i    = r_i;
        tb_j    = r_j;
        t_we    = 1'b0;
        st_we   = 1'b0;
        st_raddr = r_sp[PW-1:0] - PW'(1);
        o_mid_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res.pair_left       = 6'(r_hl);
        o_res.pair_right      = 6'(r_hr);
        o_res.pair_valid      = r_hv;
        o_res.pair_total      = 6'(r_total);
        o_res.length_overflow = r_ovf;
        o_res.last_pair       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_mid_empty) begin
                    o_mid_pop = 1'b1;
                    if (i_mid_item.keep) begin
                        n_wr = r_wr + CW'(1);
                    end
                    if (i_mid_item.last_base) begin
                        n_n     = i_mid_item.keep ? r_wr + CW'(1) : r_wr;
                        n_ovf   = i_mid_item.overflow;
                        n_wr    = '0;
                        n_state = S_FSTART;
                    end
                end
            end
            S_FSTART: begin
                n_span = PW'(1);
                n_i    = '0;
                n_j    = PW'(1);
                n_state = (r_n < CW'(2)) ? S_WINIT : S_C0;
            end
            S_C0: begin
                ta_i = i1;
                n_za = (i1 >= r_j);
                tb_j = jm1;
                n_zb = (r_i >= jm1);
                n_state = S_C1;
            end
            S_C1: begin
                n_best = (sa > sb) ? sa : sb;
                n_pr   = pair;
                ta_i   = i1;
                ta_j   = jm1;
                n_za   = (i1 >= jm1);
                n_state = S_C2;
            end
            S_C2: begin
                if (r_pr && sa1 > (SW+1)'(r_best)) begin
                    n_best = SW'(sa1);
                end
                n_k  = i1;
                n_sv = 1'b0;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                ta_j = r_k;
                n_za = (r_i >= r_k);
                tb_i = r_k + PW'(1);
                n_zb = ((r_k + PW'(1)) >= r_j);
                n_sv = issue;
                if (issue) begin
                    n_k = r_k + PW'(1);
                end
                if (r_sv && sum_ab > (SW+1)'(r_best)) begin
                    n_best = SW'(sum_ab);
                end
                if (!issue && !r_sv) begin
                    n_state = S_FWR;
                end
            end
            S_FWR: begin
                t_we = 1'b1;
                if ((CW'(r_j) + CW'(1)) < r_n) begin
                    n_i = i1;
                    n_j = r_j + PW'(1);
                    n_state = S_C0;
                end else if ((CW'(r_span) + CW'(1)) < r_n) begin
                    n_span = r_span + PW'(1);
                    n_i    = '0;
                    n_j    = r_span + PW'(1);
                    n_state = S_C0;
                end else begin
                    n_state = S_WINIT;
                end
            end
            S_WINIT: begin
                ta_i = '0;
                ta_j = PW'(r_n - CW'(1));
                n_za = (r_n < CW'(2));
                n_state = S_WTOT;
            end
            S_WTOT: begin
                n_total = sa;
                n_sp    = '0;
                n_cnt   = '0;
                n_hv    = 1'b0;
                n_pi    = '0;
                n_pj    = PW'(r_n - CW'(1));
                n_two   = 1'b0;
                n_state = (sa != '0) ? S_PUSH : S_FIN;
            end
            S_PUSH: begin
                if (r_sp < CW'(MAX_LEN)) begin
                    st_we = 1'b1;
                    n_sp  = r_sp + CW'(1);
                end
                if (r_two) begin
                    n_pi  = r_i;
                    n_pj  = r_kc;
                    n_two = 1'b0;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (r_sp == '0 || r_cnt == 6'(RESULT_CAP)) begin
                    n_state = S_FIN;
                end else begin
                    n_sp    = r_sp - CW'(1);
                    n_state = S_GET;
                end
            end
            S_GET: begin
                n_i = g_i;
                n_j = g_j;
                ta_i = g_i;
                ta_j = g_j;
                n_za = 1'b0;
                tb_i = g_i + PW'(1);
                tb_j = g_j;
                n_zb = ((g_i + PW'(1)) >= g_j);
                n_state = (g_i >= g_j) ? S_POP : S_T1;
            end
            S_T1: begin
                n_v = sa;
                if (sa == sb) begin
                    n_pi  = i1;
                    n_pj  = r_j;
                    n_two = 1'b0;
                    n_state = S_PUSH;
                end else begin
                    ta_j = jm1;
                    n_za = (r_i >= jm1);
                    tb_i = i1;
                    tb_j = jm1;
                    n_zb = (i1 >= jm1);
                    n_state = S_T2;
                end
            end
            S_T2: begin
                if (r_v == sa) begin
                    n_pi  = r_i;
                    n_pj  = jm1;
                    n_two = 1'b0;
                    n_state = S_PUSH;
                end else if (pair && (SW+1)'(r_v) == sb1) begin
                    n_state = S_EMIT;
                end else begin
                    n_k  = i1;
                    n_sv = 1'b0;
                    n_state = S_WSPLIT;
                end
            end
            S_EMIT: begin
                if (!(r_hv && i_res_full)) begin
                    o_res_push = r_hv;
                    n_hl  = r_i;
                    n_hr  = r_j;
                    n_hv  = 1'b1;
                    n_cnt = r_cnt + 6'd1;
                    n_pi  = i1;
                    n_pj  = jm1;
                    n_two = 1'b0;
                    n_state = S_PUSH;
                end
            end
            S_WSPLIT: begin
                ta_j = r_k;
                n_za = (r_i >= r_k);
                tb_i = r_k + PW'(1);
                n_zb = ((r_k + PW'(1)) >= r_j);
                n_sv = issue;
                if (issue) begin
                    n_k = r_k + PW'(1);
                end
                if (r_sv && sum_ab == (SW+1)'(r_v)) begin
                    n_pi  = r_kc + PW'(1);
                    n_pj  = r_j;
                    n_two = 1'b1;
                    n_state = S_PUSH;
                end else begin
                    n_kc = r_k;
                    if (!issue && !r_sv) begin
                        n_state = S_POP;
                    end
                end
            end
            S_FIN: begin
                o_res.last_pair = 1'b1;
                if (!r_hv) begin
                    o_res.pair_left  = '0;
                    o_res.pair_right = '0;
                end
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_hv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wr    <= '0;
            r_sp    <= '0;
            r_hv    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_wr    <= n_wr;
            r_sp    <= n_sp;
            r_hv    <= n_hv;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_ovf   <= n_ovf;
        r_span  <= n_span;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_kc    <= n_kc;
        r_pi    <= n_pi;
        r_pj    <= n_pj;
        r_hl    <= n_hl;
        r_hr    <= n_hr;
        r_best  <= n_best;
        r_v     <= n_v;
        r_total <= n_total;
        r_sv    <= n_sv;
        r_za    <= n_za;
        r_zb    <= n_zb;
        r_pr    <= n_pr;
        r_two   <= n_two;
    end

endmodule
`default_nettype wire

// ===== design/rna_base_pair_maximizer.sv =====
// Top level of the RNA base-pair maximiser
// Bases go in one per cycle while full is low, through a two-entry queue; the
// item marked last starts the fold of the buffered sequence (up to MAX_LEN
// bases, the rest are dropped and flagged). The table fill evaluates one split
// point per cycle through the two read ports of the score RAM. The walk-back
// then searches split points again for each interval that it pops from the
// stack. Results queue in a four-entry output queue; the last result of a
// sequence carries last_pair, and an empty structure gives a single result
// with pair_valid low. No clearing pass after reset.
`default_nettype none
module rna_base_pair_maximizer
    import rbp_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output      logic             full,
    input  wire logic [2:0]       i_base,
    input  wire logic             i_last_base,
    input  wire logic             i_cfg_we,
    input  wire logic [GAP_W-1:0] i_cfg_wdata,
    output      logic             empty,
    input  wire logic             pop,
    output      logic [5:0]       o_pair_left,
    output      logic [5:0]       o_pair_right,
    output      logic             o_pair_valid,
    output      logic [5:0]       o_pair_total,
    output      logic             o_length_overflow,
    output      logic             o_last_pair
);

    logic [GAP_W-1:0] r_gap;
    logic             mid_push, mid_full, mid_pop, mid_empty;
    t_mid_item        mid_in, mid_out;
    logic             res_push, res_full;
    t_result          res_in, res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
        end else if (i_cfg_we) begin
            r_gap <= i_cfg_wdata;
        end
    end

    rbp_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_base      (i_base),
        .i_last_base (i_last_base),
        .i_mid_full  (mid_full),
        .o_mid_push  (mid_push),
        .o_mid_item  (mid_in)
    );

    rbp_fifo #(.WIDTH($bits(t_mid_item)), .DEPTH(MID_FIFO_DEPTH)) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_wdata (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_rdata (mid_out),
        .o_empty (mid_empty)
    );

    rbp_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gap       (r_gap),
        .i_mid_empty (mid_empty),
        .i_mid_item  (mid_out),
        .o_mid_pop   (mid_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    rbp_fifo #(.WIDTH($bits(t_result)), .DEPTH(OUT_FIFO_DEPTH)) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_out),
        .o_empty (empty)
    );

    assign full              = mid_full;
    assign o_pair_left       = res_out.pair_left;
    assign o_pair_right      = res_out.pair_right;
    assign o_pair_valid      = res_out.pair_valid;
    assign o_pair_total      = res_out.pair_total;
    assign o_length_overflow = res_out.length_overflow;
    assign o_last_pair       = res_out.last_pair;

endmodule
`default_nettype wire
